>>> rtl/wtsp_pkg.sv
// Shared constants and types for the world-to-screen projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package wtsp_pkg;

    // Sizing
    localparam int COORD_BITS     = 20;
    localparam int AXIS_FRAC_BITS = 14;
    localparam int CAM_W          = 21;
    localparam int CAM_VEC_W      = 3 * CAM_W;
    localparam int AXIS_W         = 16;
    localparam int AXIS_VEC_W     = 3 * AXIS_W;
    localparam int SIZE_W         = 14;
    localparam int TAN_W          = 16;
    localparam int TAN_PAIR_W     = 2 * TAN_W;
    localparam int CFG_DATA_W     = CAM_VEC_W;
    localparam int CFG_IDX_W      = 3;

    localparam int DIFF_W = ((COORD_BITS > CAM_W) ? COORD_BITS : CAM_W) + 1;
    localparam int PROD_W = DIFF_W + AXIS_W;
    localparam int LAT_W  = PROD_W + 2;
    localparam int MAG_W  = LAT_W;
    localparam int DEP_W  = LAT_W - 1;

    // Depth ratio: 20 integer and 24 fraction bits, saturating
    localparam int RATIO_INT  = 20;
    localparam int RATIO_FRAC = 24;
    localparam int RATIO_W    = RATIO_INT + RATIO_FRAC;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    // Scale stage: ratio*size / (tan << 9), quotient clamped to 2^18
    localparam int SPROD_W   = RATIO_W + SIZE_W;
    localparam int TAN_SHIFT = 9;
    localparam int SNUM_W    = SPROD_W - TAN_SHIFT;
    localparam int TQ_W      = 18;
    localparam int T_W       = TQ_W + 1;
    localparam logic [T_W-1:0] T_SAT = T_W'(1) << TQ_W;

    // Screen coordinate math, Q13.4
    localparam int BASE_W = SIZE_W + 3;
    localparam int RAW_W  = T_W + 2;
    localparam int SCR_W  = 17;
    localparam logic [SCR_W-1:0] SCREEN_MAX = '1;
    localparam logic [RAW_W-1:0] SCREEN_MIN = RAW_W'(16);

    localparam logic signed [LAT_W-1:0] NEAR_LIMIT =
        LAT_W'(((1 << AXIS_FRAC_BITS) + 50) / 100);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_HALF_FOV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_POS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_FORWARD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_RIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_UP       = 3'd6;

    // Per-item flags that ride alongside the divider data
    typedef struct packed {
        logic       behind;
        logic [1:0] pos;     // lateral > 0; [0] = x, [1] = y
    } t_tag;

endpackage
`default_nettype wire

>>> rtl/world_to_screen_projection.sv
// Top level: configuration registers, projection pipeline and output stage.
`timescale 1ns / 1ps
`default_nettype none
// Projects one world point per clock onto the screen. o_busy is always low: a point
// is taken on every cycle that i_start is high, and its result appears on o_valid
// after 4 transform stages, 45 ratio divider stages, 20 scale stages and 1 output
// stage; the 44-bit and 18-bit quotients are formed one bit per pipeline stage.
// Results come one per cycle in input order and cannot be held off. Write
// configuration only when no point is in flight; each write takes effect at the
// edge it is presented.
module world_to_screen_projection (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [wtsp_pkg::COORD_BITS-1:0] i_world_x,
    input  logic signed [wtsp_pkg::COORD_BITS-1:0] i_world_y,
    input  logic signed [wtsp_pkg::COORD_BITS-1:0] i_world_z,
    input  logic                                  i_cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wtsp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_valid,
    output logic                                  o_visible,
    output logic                                  o_behind_camera,
    output logic [wtsp_pkg::SCR_W-1:0]            o_screen_x,
    output logic [wtsp_pkg::SCR_W-1:0]            o_screen_y
);
    import wtsp_pkg::*;

    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;
    logic [TAN_PAIR_W-1:0] r_tan;
    logic [CAM_VEC_W-1:0]  r_cam;
    logic [AXIS_VEC_W-1:0] r_fwd;
    logic [AXIS_VEC_W-1:0] r_right;
    logic [AXIS_VEC_W-1:0] r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(1920);
            r_height <= SIZE_W'(1080);
            r_tan    <= TAN_PAIR_W'(32'h1000_1000);
            r_cam    <= '0;
            r_fwd    <= AXIS_VEC_W'(48'h0000_0000_4000);
            r_right  <= AXIS_VEC_W'(48'h0000_4000_0000);
            r_up     <= AXIS_VEC_W'(48'h4000_0000_0000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                CFG_TAN_HALF_FOV:  r_tan    <= i_cfg_data[TAN_PAIR_W-1:0];
                CFG_CAMERA_POS:    r_cam    <= i_cfg_data[CAM_VEC_W-1:0];
                CFG_AXIS_FORWARD:  r_fwd    <= i_cfg_data[AXIS_VEC_W-1:0];
                CFG_AXIS_RIGHT:    r_right  <= i_cfg_data[AXIS_VEC_W-1:0];
                CFG_AXIS_UP:       r_up     <= i_cfg_data[AXIS_VEC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic                    xf_valid;
    logic [1:0][MAG_W-1:0]   xf_mag;
    logic [DEP_W-1:0]        xf_dep;
    t_tag                    xf_tag;

    wtsp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_world ({i_world_z, i_world_y, i_world_x}),
        .i_cam   (r_cam),
        .i_axes  ({r_fwd, r_up, r_right}),
        .o_valid (xf_valid),
        .o_mag   (xf_mag),
        .o_dep   (xf_dep),
        .o_tag   (xf_tag)
    );

    logic                    rd_valid;
    logic [1:0][RATIO_W-1:0] rd_ratio;
    t_tag                    rd_tag;

    wtsp_ratio_div u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_valid),
        .i_mag   (xf_mag),
        .i_dep   (xf_dep),
        .i_tag   (xf_tag),
        .o_valid (rd_valid),
        .o_ratio (rd_ratio),
        .o_tag   (rd_tag)
    );

    logic                sd_valid;
    logic [1:0][T_W-1:0] sd_t;
    t_tag                sd_tag;

    wtsp_scale_div u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_valid),
        .i_ratio (rd_ratio),
        .i_size  ({r_height, r_width}),
        .i_tan   ({r_tan[TAN_W-1:0], r_tan[TAN_PAIR_W-1:TAN_W]}),
        .i_tag   (rd_tag),
        .o_valid (sd_valid),
        .o_t     (sd_t),
        .o_tag   (sd_tag)
    );

    // Output stage: offset from screen center, bounds test on unclamped value, clamp
    logic [1:0][SIZE_W-1:0] w_size;
    logic [1:0][RAW_W-1:0]  w_raw;
    logic [1:0][SCR_W-1:0]  w_scr;
    logic [1:0]             w_in;
    logic                   n_visible;
    logic [SCR_W-1:0]       n_sx;
    logic [SCR_W-1:0]       n_sy;

    always_comb begin
        w_size = {r_height, r_width};
        for (int k = 0; k < 2; k++) begin
            w_raw[k] = sd_tag.pos[k]
                ? RAW_W'({w_size[k], 3'b000}) - RAW_W'(sd_t[k])
                : RAW_W'({w_size[k], 3'b000}) + RAW_W'(sd_t[k]);
            w_in[k]  = !w_raw[k][RAW_W-1] && (w_raw[k] >= SCREEN_MIN) &&
                       (w_raw[k] <= RAW_W'({w_size[k], 4'b0000}));
            if (w_raw[k][RAW_W-1]) begin
                w_scr[k] = '0;
            end else if (w_raw[k] > RAW_W'(SCREEN_MAX)) begin
                w_scr[k] = SCREEN_MAX;
            end else begin
                w_scr[k] = w_raw[k][SCR_W-1:0];
            end
        end
        if (sd_tag.behind) begin
            n_visible = 1'b0;
            n_sx      = '0;
            n_sy      = '0;
        end else begin
            n_visible = w_in[0] && w_in[1];
            n_sx      = w_scr[0];
            n_sy      = w_scr[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= sd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_visible       <= n_visible;
        o_behind_camera <= sd_tag.behind;
        o_screen_x      <= n_sx;
        o_screen_y      <= n_sy;
    end

endmodule
`default_nettype wire

>>> rtl/wtsp_xform.sv
// Camera transform: offset, axis dot products, depth test and lateral magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_xform (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  logic [2:0][wtsp_pkg::COORD_BITS-1:0]         i_world,
    input  logic [wtsp_pkg::CAM_VEC_W-1:0]               i_cam,
    input  logic [2:0][wtsp_pkg::AXIS_VEC_W-1:0]         i_axes,  // right, up, forward
    output logic                                         o_valid,
    output logic [1:0][wtsp_pkg::MAG_W-1:0]              o_mag,
    output logic [wtsp_pkg::DEP_W-1:0]                   o_dep,
    output wtsp_pkg::t_tag                               o_tag
);
    import wtsp_pkg::*;

    logic [3:0] r_valid;

    logic signed [DIFF_W-1:0] n_d   [3];
    logic signed [DIFF_W-1:0] r_d   [3];
    logic signed [PROD_W-1:0] n_p   [3][3];
    logic signed [PROD_W-1:0] r_p   [3][3];
    logic signed [LAT_W-1:0]  n_lat [3];
    logic signed [LAT_W-1:0]  r_lat [3];

    logic [1:0][MAG_W-1:0] n_mag;
    logic [DEP_W-1:0]      n_dep;
    t_tag                  n_tag;
    logic [1:0][MAG_W-1:0] r_mag;
    logic [DEP_W-1:0]      r_dep;
    t_tag                  r_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = DIFF_W'($signed(i_world[i])) -
                     DIFF_W'($signed(i_cam[CAM_W*i +: CAM_W]));
        end
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
                n_p[a][i] = r_d[i] * $signed(i_axes[a][AXIS_W*i +: AXIS_W]);
            end
            n_lat[a] = LAT_W'(r_p[a][0]) + LAT_W'(r_p[a][1]) + LAT_W'(r_p[a][2]);
        end
        for (int k = 0; k < 2; k++) begin
            n_mag[k]     = r_lat[k][LAT_W-1] ? MAG_W'(-r_lat[k]) : MAG_W'(r_lat[k]);
            n_tag.pos[k] = !r_lat[k][LAT_W-1] && (r_lat[k] != '0);
        end
        n_tag.behind = r_lat[2] < NEAR_LIMIT;
        n_dep        = r_lat[2][DEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d   <= n_d;
        r_p   <= n_p;
        r_lat <= n_lat;
        r_mag <= n_mag;
        r_dep <= n_dep;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid[3];
    assign o_mag   = r_mag;
    assign o_dep   = r_dep;
    assign o_tag   = r_tag;

endmodule
`default_nettype wire

>>> rtl/wtsp_ratio_div.sv
// Pipelined restoring divider: lateral/depth ratio, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_ratio_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [1:0][wtsp_pkg::MAG_W-1:0]        i_mag,
    input  logic [wtsp_pkg::DEP_W-1:0]             i_dep,
    input  wtsp_pkg::t_tag                         i_tag,
    output logic                                   o_valid,
    output logic [1:0][wtsp_pkg::RATIO_W-1:0]      o_ratio,
    output wtsp_pkg::t_tag                         o_tag
);
    import wtsp_pkg::*;

    localparam int PAD_W = DEP_W + RATIO_INT - MAG_W;

    logic                        r_valid [0:RATIO_W];
    logic [DEP_W-1:0]            r_dep   [0:RATIO_W];
    t_tag                        r_tag   [0:RATIO_W];
    logic [1:0]                  r_sat   [0:RATIO_W];
    logic [1:0][DEP_W-1:0]       r_rem   [0:RATIO_W];
    logic [1:0][RATIO_INT-1:0]   r_low   [0:RATIO_W];
    logic [1:0][RATIO_W-1:0]     r_q     [0:RATIO_W];

    logic [1:0]            n_sat;
    logic [1:0][DEP_W-1:0] n_rem;

    // ratio >= 2^20 saturates; otherwise the magnitude bits above the low 20 seed the remainder
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_sat[k] = {{PAD_W{1'b0}}, i_mag[k]} >= {i_dep, {RATIO_INT{1'b0}}};
            n_rem[k] = DEP_W'(i_mag[k][MAG_W-1:RATIO_INT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dep[0] <= i_dep;
        r_tag[0] <= i_tag;
        r_sat[0] <= n_sat;
        r_rem[0] <= n_rem;
        for (int k = 0; k < 2; k++) begin
            r_low[0][k] <= i_mag[k][RATIO_INT-1:0];
        end
        r_q[0] <= '0;
    end

    for (genvar j = 0; j < RATIO_W; j++) begin : g_step
        logic [1:0][DEP_W:0] w_trial;
        logic [1:0]          w_ge;

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                w_trial[k] = {r_rem[j][k], r_low[j][k][RATIO_INT-1]};
                w_ge[k]    = w_trial[k] >= {1'b0, r_dep[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else begin
                r_valid[j+1] <= r_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dep[j+1] <= r_dep[j];
            r_tag[j+1] <= r_tag[j];
            r_sat[j+1] <= r_sat[j];
            for (int k = 0; k < 2; k++) begin
                r_rem[j+1][k] <= w_ge[k] ? DEP_W'(w_trial[k] - {1'b0, r_dep[j]})
                                         : w_trial[k][DEP_W-1:0];
                r_low[j+1][k] <= r_low[j][k] << 1;
                r_q[j+1][k]   <= {r_q[j][k][RATIO_W-2:0], w_ge[k]};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            o_ratio[k] = r_sat[RATIO_W][k] ? RATIO_MAX : r_q[RATIO_W][k];
        end
    end

    assign o_valid = r_valid[RATIO_W];
    assign o_tag   = r_tag[RATIO_W];

endmodule
`default_nettype wire

>>> rtl/wtsp_scale_div.sv
// Screen scaling: ratio*size, then pipelined division by the FOV tangent.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_scale_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [1:0][wtsp_pkg::RATIO_W-1:0]      i_ratio,
    input  logic [1:0][wtsp_pkg::SIZE_W-1:0]       i_size,
    input  logic [1:0][wtsp_pkg::TAN_W-1:0]        i_tan,
    input  wtsp_pkg::t_tag                         i_tag,
    output logic                                   o_valid,
    output logic [1:0][wtsp_pkg::T_W-1:0]          o_t,
    output wtsp_pkg::t_tag                         o_tag
);
    import wtsp_pkg::*;

    localparam int TPAD_W = SNUM_W - TAN_W - TQ_W;

    logic                    r_pvalid;
    t_tag                    r_ptag;
    logic [1:0][SPROD_W-1:0] r_prod;
    logic [1:0][SPROD_W-1:0] n_prod;

    logic [1:0][TAN_W-1:0]   w_tan;
    logic [1:0][SNUM_W-1:0]  w_num;

    logic                    r_valid [0:TQ_W];
    t_tag                    r_tag   [0:TQ_W];
    logic [1:0]              r_sat   [0:TQ_W];
    logic [1:0][TAN_W-1:0]   r_rem   [0:TQ_W];
    logic [1:0][TQ_W-1:0]    r_low   [0:TQ_W];
    logic [1:0][TQ_W-1:0]    r_q     [0:TQ_W];

    logic [1:0]              n_sat;

    // a zero tangent acts as the smallest step; floor(floor(a/512)/tan) = floor(a/(tan*512))
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_prod[k] = i_ratio[k] * i_size[k];
            w_tan[k]  = (i_tan[k] == '0) ? TAN_W'(1) : i_tan[k];
            w_num[k]  = r_prod[k][SPROD_W-1:TAN_SHIFT];
            n_sat[k]  = w_num[k] >= {{TPAD_W{1'b0}}, w_tan[k], {TQ_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid   <= 1'b0;
            r_valid[0] <= 1'b0;
        end else begin
            r_pvalid   <= i_valid;
            r_valid[0] <= r_pvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_ptag   <= i_tag;
        r_tag[0] <= r_ptag;
        r_sat[0] <= n_sat;
        for (int k = 0; k < 2; k++) begin
            r_rem[0][k] <= w_num[k][TQ_W +: TAN_W];
            r_low[0][k] <= w_num[k][TQ_W-1:0];
        end
        r_q[0] <= '0;
    end

    for (genvar j = 0; j < TQ_W; j++) begin : g_step
        logic [1:0][TAN_W:0] w_trial;
        logic [1:0]          w_ge;

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                w_trial[k] = {r_rem[j][k], r_low[j][k][TQ_W-1]};
                w_ge[k]    = w_trial[k] >= {1'b0, w_tan[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else begin
                r_valid[j+1] <= r_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[j+1] <= r_tag[j];
            r_sat[j+1] <= r_sat[j];
            for (int k = 0; k < 2; k++) begin
                r_rem[j+1][k] <= w_ge[k] ? TAN_W'(w_trial[k] - {1'b0, w_tan[k]})
                                         : w_trial[k][TAN_W-1:0];
                r_low[j+1][k] <= r_low[j][k] << 1;
                r_q[j+1][k]   <= {r_q[j][k][TQ_W-2:0], w_ge[k]};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            o_t[k] = r_sat[TQ_W][k] ? T_SAT : {1'b0, r_q[TQ_W][k]};
        end
    end

    assign o_valid = r_valid[TQ_W];
    assign o_tag   = r_tag[TQ_W];

endmodule
`default_nettype wire

>>> tb/sv/tb_world_to_screen_projection.sv
// Testbench for world_to_screen_projection: directed and random points against a predictor.
`timescale 1ns / 1ps

module tb_world_to_screen_projection;
    import wtsp_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        bit        visible;
        bit        behind;
        bit [16:0] sx;
        bit [16:0] sy;
    } t_point_result;

    class projection_scoreboard;
        bit [13:0]     width;
        bit [13:0]     height;
        bit [31:0]     tan_pair;
        bit [62:0]     cam;
        bit [47:0]     ax_fwd;
        bit [47:0]     ax_right;
        bit [47:0]     ax_up;
        t_point_result pending[$];
        int            errors;

        function new();
            width    = 14'd1920;
            height   = 14'd1080;
            tan_pair = 32'h1000_1000;
            cam      = '0;
            ax_fwd   = 48'd16384;
            ax_right = 48'd16384 << 16;
            ax_up    = 48'd16384 << 32;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCREEN_WIDTH:  width    = val[13:0];
                CFG_SCREEN_HEIGHT: height   = val[13:0];
                CFG_TAN_HALF_FOV:  tan_pair = val[31:0];
                CFG_CAMERA_POS:    cam      = val[62:0];
                CFG_AXIS_FORWARD:  ax_fwd   = val[47:0];
                CFG_AXIS_RIGHT:    ax_right = val[47:0];
                CFG_AXIS_UP:       ax_up    = val[47:0];
                default: ;
            endcase
        endfunction

        function longint dot_axis(longint d0, longint d1, longint d2, bit [47:0] ax);
            return d0 * longint'($signed(ax[15:0])) + d1 * longint'($signed(ax[31:16]))
                 + d2 * longint'($signed(ax[47:32]));
        endfunction

        // raw Q13.4 coordinate before clamping
        function longint screen_raw(longint lat, longint depth, bit [13:0] size,
                                    bit [15:0] tan_q);
            longint unsigned mag;
            longint unsigned ratio;
            longint unsigned t;
            longint unsigned tn;
            longint          base;
            mag  = lat < 0 ? longint'(-lat) : lat;
            tn   = (tan_q == 0) ? 1 : tan_q;
            base = longint'(size) * 8;
            if (mag / longint'(depth) >= (64'd1 << 20))
                ratio = (64'd1 << 44) - 1;
            else
                ratio = (mag << 24) / longint'(depth);
            t = (ratio * size) / (tn << 9);
            return lat > 0 ? base - longint'(t) : base + longint'(t);
        endfunction

        function bit [16:0] clamp17(longint v);
            if (v < 0) return 0;
            if (v > 131071) return 17'h1FFFF;
            return v[16:0];
        endfunction

        function void note_point(logic signed [19:0] wx, logic signed [19:0] wy,
                                 logic signed [19:0] wz);
            longint        d0, d1, d2, lx, ly, dep, rx, ry;
            t_point_result r;
            d0  = longint'(wx) - longint'($signed(cam[20:0]));
            d1  = longint'(wy) - longint'($signed(cam[41:21]));
            d2  = longint'(wz) - longint'($signed(cam[62:42]));
            lx  = dot_axis(d0, d1, d2, ax_right);
            ly  = dot_axis(d0, d1, d2, ax_up);
            dep = dot_axis(d0, d1, d2, ax_fwd);
            if (dep < 164) begin
                r.visible = 0;
                r.behind  = 1;
                r.sx      = 0;
                r.sy      = 0;
            end else begin
                rx = screen_raw(lx, dep, width, tan_pair[31:16]);
                ry = screen_raw(ly, dep, height, tan_pair[15:0]);
                r.visible = rx >= 16 && rx <= longint'(width) * 16 &&
                            ry >= 16 && ry <= longint'(height) * 16;
                r.behind  = 0;
                r.sx      = clamp17(rx);
                r.sy      = clamp17(ry);
            end
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(bit vis, bit behind, bit [16:0] sx, bit [16:0] sy);
            t_point_result e;
            if (pending.size() == 0) begin
                report("unexpected result, queue depth", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (vis != e.visible) report("visible", vis, e.visible);
            if (behind != e.behind) report("behind_camera", behind, e.behind);
            if (sx != e.sx) report("screen_x", sx, e.sx);
            if (sy != e.sy) report("screen_y", sy, e.sy);
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic                         o_busy;
    logic signed [COORD_BITS-1:0] i_world_x = '0;
    logic signed [COORD_BITS-1:0] i_world_y = '0;
    logic signed [COORD_BITS-1:0] i_world_z = '0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         o_valid;
    logic                         o_visible;
    logic                         o_behind_camera;
    logic [SCR_W-1:0]             o_screen_x;
    logic [SCR_W-1:0]             o_screen_y;

    projection_scoreboard sb = new();
    int  stall_cycles = 0;
    bit  progress;
    bit  allow_idle = 1'b1;

    world_to_screen_projection DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // results are sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        progress = 1'b0;
        if (o_valid) begin
            sb.check_result(o_visible, o_behind_camera, o_screen_x, o_screen_y);
            progress = 1'b1;
        end
        if (i_start && !o_busy) progress = 1'b1;
        stall_cycles = progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // called at a rising-edge step; returns at the edge that takes the item, or after a random idle gap
    task send_point(logic signed [19:0] x, logic signed [19:0] y, logic signed [19:0] z);
        bit taken;
        i_start   <= 1'b1;
        i_world_x <= x;
        i_world_y <= y;
        i_world_z <= z;
        do begin
            @(negedge i_clk);
            taken = !o_busy;
            if (taken) sb.note_point(x, y, z);
            @(posedge i_clk);
        end while (!taken);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one write cycle, then a quiet spell with the enable low before returning
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [47:0] make_axis(int sx, int sy, int sz);
        return {16'(sz), 16'(sy), 16'(sx)};
    endfunction

    function logic [62:0] make_cam(int cx, int cy, int cz);
        return {21'(cz), 21'(cy), 21'(cx)};
    endfunction

    function logic [CFG_DATA_W-1:0] rand63();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    task random_config();
        bit [15:0] f;
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_AXIS_FORWARD, rand63());
            cfg_write(CFG_AXIS_RIGHT, rand63());
            cfg_write(CFG_AXIS_UP, rand63());
            cfg_write(CFG_CAMERA_POS, rand63());
            cfg_write(CFG_TAN_HALF_FOV, CFG_DATA_W'($urandom));
        end else begin
            // plausible camera: axis-aligned frame, sign chosen at random
            f = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
            cfg_write(CFG_AXIS_FORWARD, CFG_DATA_W'(make_axis(0, 0, int'($signed(f)))));
            cfg_write(CFG_AXIS_RIGHT,
                      CFG_DATA_W'(make_axis($urandom_range(8000, 16384), 0, 0)));
            cfg_write(CFG_AXIS_UP,
                      CFG_DATA_W'(make_axis(0, -int'($urandom_range(8000, 16384)), 0)));
            cfg_write(CFG_CAMERA_POS, make_cam(int'($urandom_range(0, 4000)) - 2000,
                      int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000));
            cfg_write(CFG_TAN_HALF_FOV, CFG_DATA_W'({16'($urandom_range(1000, 12000)),
                      16'($urandom_range(1000, 12000))}));
        end
        cfg_write(CFG_SCREEN_WIDTH, CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom
                                                 : $urandom_range(1, 4096)));
        cfg_write(CFG_SCREEN_HEIGHT, CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom
                                                  : $urandom_range(1, 4096)));
    endtask

    task random_points(int count);
        logic signed [19:0] x, y, z;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: begin
                    x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
                end
                1: begin
                    x = 20'(int'($urandom_range(0, 200)) - 100);
                    y = 20'(int'($urandom_range(0, 200)) - 100);
                    z = 20'(int'($urandom_range(0, 200)) - 100);
                end
                default: begin
                    x = 20'(int'($urandom_range(0, 8000)) - 4000);
                    y = 20'(int'($urandom_range(0, 8000)) - 4000);
                    z = 20'(int'($urandom_range(0, 8000)) - 4000);
                end
            endcase
            send_point(x, y, z);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame: forward is +x, right +y, up +z
        send_point(1000, 0, 0);
        send_point(0, 0, 0);
        send_point(20'sh7FFFF, 20'sh80000, 20'sh7FFFF);
        send_point(20'sh80000, 20'sh7FFFF, 20'sh80000);
        send_point(1000, 500, -300);
        send_point(1000, -999, 999);
        send_point(1, 20'sh7FFFF, 20'sh80000);
        drain();

        // unit forward weight so depth lands on the near threshold
        cfg_write(CFG_AXIS_FORWARD, CFG_DATA_W'(make_axis(1, 0, 0)));
        cfg_write(CFG_AXIS_RIGHT, CFG_DATA_W'(make_axis(0, 1, 0)));
        cfg_write(CFG_AXIS_UP, CFG_DATA_W'(make_axis(0, 0, 1)));
        send_point(163, 0, 0);
        send_point(164, 0, 0);
        send_point(164, 20'sh7FFFF, 20'sh80000);
        send_point(165, 3, -3);
        drain();

        // zero tangent, zero width, widest height
        cfg_write(CFG_TAN_HALF_FOV, CFG_DATA_W'(32'h0000_0000));
        cfg_write(CFG_SCREEN_WIDTH, CFG_DATA_W'(14'd0));
        cfg_write(CFG_SCREEN_HEIGHT, CFG_DATA_W'(14'h3FFF));
        send_point(5000, 0, 0);
        send_point(5000, 1, -1);
        send_point(300, 20'sh7FFFF, 20'sh7FFFF);
        drain();

        // extreme camera and full-scale axes: forward negative, right positive, up mixed
        cfg_write(CFG_TAN_HALF_FOV, CFG_DATA_W'(32'hFFFF_FFFF));
        cfg_write(CFG_SCREEN_WIDTH, CFG_DATA_W'(14'd8192));
        cfg_write(CFG_SCREEN_HEIGHT, CFG_DATA_W'(14'd1));
        cfg_write(CFG_CAMERA_POS, make_cam(1048575, -1048576, 1048575));
        cfg_write(CFG_AXIS_FORWARD, CFG_DATA_W'({16'h8000, 16'h8000, 16'h8000}));
        cfg_write(CFG_AXIS_RIGHT, CFG_DATA_W'({16'h7FFF, 16'h7FFF, 16'h7FFF}));
        cfg_write(CFG_AXIS_UP, CFG_DATA_W'({16'h8000, 16'h7FFF, 16'h8000}));
        send_point(20'sh80000, 20'sh7FFFF, 20'sh80000);
        send_point(20'sh7FFFF, 20'sh80000, 20'sh7FFFF);
        send_point(0, 0, 0);
        send_point(20'sh80000, 20'sh80000, 20'sh80000);
        drain();

        repeat (8) begin
            random_config();
            random_points(80);
            drain();
        end

        // closing stretch: back-to-back items, no gaps
        allow_idle = 1'b0;
        random_config();
        random_points(70);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
